/* rtl/emfd_pkg.sv */
// Shared constants and types for the energy meter frame decoder.
package emfd_pkg;

    // Header bytes that open a frame
    localparam logic [7:0] HDR_STATE = 8'h55;
    localparam logic [7:0] HDR_CHECK = 8'h5A;

    // Frame positions: 0 while hunting, FIRST_POS..SUM_POS inside a frame
    localparam int         POS_W     = 5;
    localparam logic [POS_W-1:0] HUNT_POS  = 5'd0;
    localparam logic [POS_W-1:0] FIRST_POS = 5'd2;
    localparam logic [POS_W-1:0] SUM_POS   = 5'd23;

    // Frame bytes 2..22 are kept; store entry i holds frame byte i+2
    localparam int STORE_DEPTH = 21;

    // Store entries of the frame fields
    localparam int VOLT_PARAM_IDX = 0;
    localparam int VOLT_COEF_IDX  = 3;
    localparam int CURR_PARAM_IDX = 6;
    localparam int CURR_COEF_IDX  = 9;
    localparam int POW_PARAM_IDX  = 12;
    localparam int POW_COEF_IDX   = 15;
    localparam int FLAGS_IDX      = 18;
    localparam int PULSE_IDX      = 19;

    // Flag bits in the flag byte
    localparam int FLAG_OVERFLOW  = 7;
    localparam int FLAG_VOLT_COEF = 6;
    localparam int FLAG_CURR_COEF = 5;
    localparam int FLAG_POW_COEF  = 4;

    typedef logic [STORE_DEPTH-1:0][7:0] frame_store_t;

    // Status from the frame tracker to the top level
    typedef struct packed {
        logic at_sum_pos;   // next byte taken is the checksum byte
        logic sum_ok;       // running sum equals the byte on offer
    } sync_status_t;

endpackage

/* rtl/emfd_frame_sync.sv */
// Header hunting, byte position, running sum and payload store.
module emfd_frame_sync
    import emfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_en,
    input  logic [7:0]   byte_in,
    output sync_status_t status,
    output frame_store_t store
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             hdr_reg;
    logic             hdr_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    frame_store_t     store_reg;
    logic             store_shift;

    // Next state for one byte
    always_comb
    begin
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        sum_next    = sum_reg;
        store_shift = 1'b0;
        if (byte_en)
        begin
            if (pos_reg != HUNT_POS)
            begin
                if (pos_reg != SUM_POS)
                begin
                    // payload byte, header values are not looked at here
                    store_shift = 1'b1;
                    sum_next    = sum_reg + byte_in;
                    pos_next    = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = HUNT_POS;
                    hdr_next = 1'b0;
                end
            end
            else if (byte_in == HDR_STATE)
            begin
                hdr_next = 1'b1;
            end
            else if (byte_in == HDR_CHECK && hdr_reg)
            begin
                pos_next = FIRST_POS;
                sum_next = 8'd0;
            end
            else
            begin
                hdr_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= HUNT_POS;
            hdr_reg <= 1'b0;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            sum_reg <= sum_next;
        end
    end

    // Payload shift line: oldest byte ends at entry 0
    always_ff @(posedge clk)
    begin
        if (store_shift)
        begin
            store_reg <= {byte_in, store_reg[STORE_DEPTH-1:1]};
        end
    end

    assign status.at_sum_pos = (pos_reg == SUM_POS);
    assign status.sum_ok     = (sum_reg == byte_in);
    assign store             = store_reg;

endmodule

/* rtl/energy_meter_frame_decoder.sv */
// A result is registered: the checksum byte waits in the input register and sets the result flag as it moves on.
// Throughput: one byte per cycle; a frame end waits only while the previous result stalls.
// A byte is held in an input register, the result flag in an output register.
// Reset (rst_n low, asynchronous) clears position, header, sum and all held meter values.
// The payload store needs no clearing; every entry is written before it is read.
module energy_meter_frame_decoder
    import emfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        checksum_ok,
    output logic [23:0] voltage_param,
    output logic [23:0] voltage_coef,
    output logic [23:0] current_param,
    output logic [23:0] current_coef,
    output logic [23:0] power_param,
    output logic [23:0] power_coef,
    output logic [15:0] pulse_count,
    output logic [31:0] pulse_overflows
);

    logic         in_full_reg;
    logic [7:0]   in_byte_reg;
    logic         res_valid_reg;
    logic         ok_reg;
    logic [23:0]  volt_param_reg;
    logic [23:0]  volt_coef_reg;
    logic [23:0]  curr_param_reg;
    logic [23:0]  curr_coef_reg;
    logic [23:0]  pow_param_reg;
    logic [23:0]  pow_coef_reg;
    logic [15:0]  pulse_reg;
    logic [31:0]  overflow_reg;

    sync_status_t status;
    frame_store_t store;
    logic         slot_free;
    logic         advance;
    logic         frame_end;
    logic         load;
    logic [7:0]   flags;

    // Byte moves on unless it closes a frame and the result slot holds a stalled result
    assign slot_free = !res_valid_reg || !res_stall;
    assign advance   = in_full_reg && (!status.at_sum_pos || slot_free);
    assign frame_end = advance && status.at_sum_pos;
    assign load      = frame_end && status.sum_ok;
    assign rx_stall  = in_full_reg && !advance;
    assign flags     = store[FLAGS_IDX];

    emfd_frame_sync u_sync (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (advance),
        .byte_in (in_byte_reg),
        .status  (status),
        .store   (store)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_full_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (frame_end)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            ok_reg <= status.sum_ok;
        end
    end

    // Held meter values, loaded from a good frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_param_reg <= 24'd0;
            volt_coef_reg  <= 24'd0;
            curr_param_reg <= 24'd0;
            curr_coef_reg  <= 24'd0;
            pow_param_reg  <= 24'd0;
            pow_coef_reg   <= 24'd0;
            pulse_reg      <= 16'd0;
            overflow_reg   <= 32'd0;
        end
        else if (load)
        begin
            volt_param_reg <= {store[VOLT_PARAM_IDX], store[VOLT_PARAM_IDX+1],
                               store[VOLT_PARAM_IDX+2]};
            curr_param_reg <= {store[CURR_PARAM_IDX], store[CURR_PARAM_IDX+1],
                               store[CURR_PARAM_IDX+2]};
            pow_param_reg  <= {store[POW_PARAM_IDX], store[POW_PARAM_IDX+1],
                               store[POW_PARAM_IDX+2]};
            pulse_reg      <= {store[PULSE_IDX], store[PULSE_IDX+1]};
            if (flags[FLAG_VOLT_COEF])
            begin
                volt_coef_reg <= {store[VOLT_COEF_IDX], store[VOLT_COEF_IDX+1],
                                  store[VOLT_COEF_IDX+2]};
            end
            if (flags[FLAG_CURR_COEF])
            begin
                curr_coef_reg <= {store[CURR_COEF_IDX], store[CURR_COEF_IDX+1],
                                  store[CURR_COEF_IDX+2]};
            end
            if (flags[FLAG_POW_COEF])
            begin
                pow_coef_reg <= {store[POW_COEF_IDX], store[POW_COEF_IDX+1],
                                 store[POW_COEF_IDX+2]};
            end
            if (flags[FLAG_OVERFLOW])
            begin
                overflow_reg <= overflow_reg + 32'd1;
            end
        end
    end

    assign res_valid       = res_valid_reg;
    assign checksum_ok     = ok_reg;
    assign voltage_param   = volt_param_reg;
    assign voltage_coef    = volt_coef_reg;
    assign current_param   = curr_param_reg;
    assign current_coef    = curr_coef_reg;
    assign power_param     = pow_param_reg;
    assign power_coef      = pow_coef_reg;
    assign pulse_count     = pulse_reg;
    assign pulse_overflows = overflow_reg;

endmodule

/* rtl/emfd_checker.sv */
// Port-level checks for the energy meter frame decoder, bound to the top level.
module emfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic        checksum_ok,
    input logic [23:0] voltage_param,
    input logic [23:0] voltage_coef,
    input logic [23:0] current_param,
    input logic [23:0] current_coef,
    input logic [23:0] power_param,
    input logic [23:0] power_coef,
    input logic [15:0] pulse_count,
    input logic [31:0] pulse_overflows
);

    // A stalled result request stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its flag and pulse count
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(checksum_ok) && $stable(pulse_count))
        else $error("result changed while stalled");

    // Overflow count moves only with a good frame result
    a_ovf_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pulse_overflows) |-> res_valid && checksum_ok)
        else $error("overflow count changed without a good frame");

    // Held parameters and coefficients move only with a good frame result
    a_param_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(voltage_param) || !$stable(current_param) || !$stable(power_param)
        || !$stable(voltage_coef) || !$stable(current_coef) || !$stable(power_coef)
        |-> res_valid && checksum_ok)
        else $error("parameters changed without a good frame");

    // Input stalls only behind a result that is itself stalled
    a_rx_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> res_valid && res_stall)
        else $error("input stalled without a stalled result");

endmodule

bind energy_meter_frame_decoder emfd_checker u_emfd_checker (.*);
